### rtl/core/tlb_lru_lfu_replacement_top_defines.svh
// Assertion macros used by the port checker of the TLB replacement block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef TLB_LRU_LFU_REPLACEMENT_TOP_DEFINES_SVH
`define TLB_LRU_LFU_REPLACEMENT_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define TLBREP_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TLBREP_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/tlbrep_pkg.sv
// Package of the TLB replacement block: widths, register codes and the structs
// that pass between the entry cells and the top level. No dependencies.
package tlbrep_pkg;

  localparam int unsigned TAG_W      = 32;
  localparam int unsigned FREQ_W     = 32;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned FIU_W      = 5;
  localparam int unsigned FRAMES_DEF = 16;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 1'b1;

  localparam logic MODE_LRU = 1'b0;
  localparam logic MODE_LFU = 1'b1;

  localparam logic [FIU_W-1:0] FIU_RESET = 5'd16;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic              valid;
    logic [FREQ_W-1:0] freq;
  } entry_t;

  // Travels from cell k to cell k+1.
  typedef struct packed {
    logic              any;
    logic              valid;
    logic [FREQ_W-1:0] freq;
    logic              go;
  } fwd_t;

  // Travels from cell k+1 to cell k.
  typedef struct packed {
    entry_t entry;
    logic   gt;
    logic   in_use;
  } back_t;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    logic              do_match;
    logic              do_sel;
    logic              do_move;
    logic              lfu;
    logic              hit_any;
    logic [TAG_W-1:0]  page;
    logic [FREQ_W-1:0] nf;
  } ctl_t;

endpackage

### rtl/core/tlbrep_if.sv
// Handshake interfaces of the TLB replacement block: page requests, results
// and configuration writes. Depends on tlbrep_pkg.
interface tlbrep_page_if;
  logic                         valid;
  logic                         ready;
  logic [tlbrep_pkg::TAG_W-1:0] page_addr;

  modport source (output valid, output page_addr, input ready);
  modport sink (input valid, input page_addr, output ready);
endinterface

interface tlbrep_result_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic [tlbrep_pkg::CNT_W-1:0] miss_total;

  modport source (output valid, output hit, output miss_total, input ready);
  modport sink (input valid, input hit, input miss_total, output ready);
endinterface

interface tlbrep_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tlbrep_pkg::CFG_IDX_W-1:0]  index;
  logic [tlbrep_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/tlbrep_cell.sv
// One entry cell of the TLB replacement chain: tag, valid bit and use count.
// Depends on tlbrep_pkg; chained by tlb_lru_lfu_replacement_top.
module tlbrep_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                is_head,
  input  logic                in_use,
  input  tlbrep_pkg::ctl_t    ctl,
  input  tlbrep_pkg::fwd_t    fwd_in,
  output tlbrep_pkg::fwd_t    fwd_out,
  input  tlbrep_pkg::back_t   back_in,
  output tlbrep_pkg::back_t   back_out
);
  import tlbrep_pkg::*;

  entry_t ent;
  logic   match_q;
  logic   touch_q;
  logic   first;
  logic   here;
  logic   can_move;
  entry_t touched;

  // The first matching cell from the head owns the hit.
  assign first    = match_q && !fwd_in.any;
  assign here     = touch_q || fwd_in.go;
  assign can_move = back_in.in_use && (!ctl.lfu || !back_in.gt);

  assign touched.tag   = ctl.page;
  assign touched.valid = 1'b1;
  assign touched.freq  = ctl.nf;

  assign fwd_out.any   = fwd_in.any || match_q;
  assign fwd_out.valid = fwd_in.valid || (first && ent.valid);
  assign fwd_out.freq  = fwd_in.freq | (first ? ent.freq : '0);
  assign fwd_out.go    = here && can_move;

  assign back_out.entry  = ent;
  assign back_out.gt     = ent.valid && (ent.freq > ctl.nf);
  assign back_out.in_use = in_use;

  always_ff @(posedge clk) begin
    if (ctl.do_match) begin
      match_q <= in_use && ent.valid && (ent.tag == ctl.page);
    end
    if (ctl.do_sel) begin
      touch_q <= ctl.hit_any ? first : is_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else if (ctl.do_move && here) begin
      if (can_move) begin
        ent <= back_in.entry;
      end else begin
        ent <= touched;
      end
    end
  end

endmodule

### rtl/core/tlb_lru_lfu_replacement_top.sv
// Top level of the TLB replacement block: sequencer, configuration registers
// and a chain of tlbrep_cell. Depends on tlbrep_pkg and tlbrep_if.
//
// The block is a fully associative table of ordered entries kept in a chain
// of cells, one entry per cell, with position 0 at the head. After
// acceptance each page word passes through S_MATCH, S_SEL and S_MOVE: in
// S_MATCH every cell compares its tag with the page, in S_SEL the first
// matching cell is found by a ripple along the chain and the new use count
// of the touched entry is computed, and in S_MOVE every cell in the
// affected run loads its right neighbor while the touched entry lands at
// its final place. The length of the chain ripple in S_SEL and S_MOVE sets
// the clock period. A new page word is taken only in S_IDLE, so not while
// the previous one is still in the cells, but as soon as it has left them,
// even while its result word still waits at the output; a result that
// finds the output register occupied waits in S_HOLD and holds off the next
// page. Configuration writes are always taken and are meant to arrive only
// while no page word is in flight.
module tlb_lru_lfu_replacement_top #(
  parameter int unsigned FRAMES = tlbrep_pkg::FRAMES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  tlbrep_page_if.sink            req,
  tlbrep_result_if.source        rsp,
  tlbrep_cfg_if.sink             cfg
);
  import tlbrep_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_SEL,
    S_MOVE,
    S_HOLD
  } state_t;

  state_t              state;
  logic [TAG_W-1:0]    page;
  logic                policy_mode;
  logic [FIU_W-1:0]    frames_in_use;
  logic [CNT_W-1:0]    miss_cnt;
  logic                found_q;
  logic [FREQ_W-1:0]   nf_q;
  logic                rsp_valid;
  logic                rsp_hit;
  logic [CNT_W-1:0]    rsp_miss;

  ctl_t                ctl;
  fwd_t                fwd  [FRAMES+1];
  back_t               back [FRAMES+1];
  logic [FRAMES-1:0]   in_use;

  logic                hit_any;
  logic                sel_valid;
  logic [FREQ_W-1:0]   sel_freq;
  logic [FREQ_W-1:0]   nf_next;
  logic                rsp_free;

  // Configuration writes land at once; the port never stalls.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy_mode   <= MODE_LRU;
      frames_in_use <= FIU_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_POLICY: policy_mode   <= cfg.data[0];
        CFG_FRAMES: frames_in_use <= cfg.data[FIU_W-1:0];
        default: ;
      endcase
    end
  end

  // Entry 0 always takes part, so a count of zero acts as one; entries past
  // the built depth do not exist, so a larger count acts as the full chain.
  for (genvar k = 0; k < FRAMES; k++) begin : g_use
    assign in_use[k] = (k == 0) || (32'(k) < 32'(frames_in_use));
  end

  // Broadcast control for the cells.
  assign hit_any      = fwd[FRAMES].any;
  assign ctl.do_match = (state == S_MATCH);
  assign ctl.do_sel   = (state == S_SEL);
  assign ctl.do_move  = (state == S_MOVE);
  assign ctl.lfu      = (policy_mode == MODE_LFU);
  assign ctl.hit_any  = hit_any;
  assign ctl.page     = page;
  assign ctl.nf       = nf_q;

  // Ends of the chain: nothing enters at the head, and past the tail there
  // is no neighbor to swap with.
  assign fwd[0]              = '0;
  assign back[FRAMES].entry  = '0;
  assign back[FRAMES].gt     = 1'b0;
  assign back[FRAMES].in_use = 1'b0;

  for (genvar k = 0; k < FRAMES; k++) begin : g_cell
    tlbrep_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .is_head  (k == 0),
      .in_use   (in_use[k]),
      .ctl      (ctl),
      .fwd_in   (fwd[k]),
      .fwd_out  (fwd[k+1]),
      .back_in  (back[k+1]),
      .back_out (back[k])
    );
  end

  // The touched entry is the first hit, or the head entry on a miss. Its new
  // count is its old count plus one, saturating, with an empty entry as minus
  // one; a miss under the frequency policy starts the new entry at zero.
  assign sel_valid = hit_any ? fwd[FRAMES].valid : back[0].entry.valid;
  assign sel_freq  = hit_any ? fwd[FRAMES].freq  : back[0].entry.freq;

  always_comb begin
    if (!hit_any && ctl.lfu) begin
      nf_next = '0;
    end else if (!sel_valid) begin
      nf_next = '0;
    end else if (sel_freq == '1) begin
      nf_next = sel_freq;
    end else begin
      nf_next = sel_freq + 1'b1;
    end
  end

  assign rsp_free       = !rsp_valid || rsp.ready;
  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = rsp_valid;
  assign rsp.hit        = rsp_hit;
  assign rsp.miss_total = rsp_miss;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      miss_cnt  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // A new result word takes the output register when it is free;
      // otherwise a taken result word leaves it.
      if (((state == S_MOVE) || (state == S_HOLD)) && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            page  <= req.page_addr;
            state <= S_MATCH;
          end
        end
        S_MATCH: begin
          state <= S_SEL;
        end
        S_SEL: begin
          found_q <= hit_any;
          nf_q    <= nf_next;
          if (!hit_any && (miss_cnt != '1)) begin
            miss_cnt <= miss_cnt + 1'b1;
          end
          state <= S_MOVE;
        end
        S_MOVE, S_HOLD: begin
          if (rsp_free) begin
            rsp_hit   <= found_q;
            rsp_miss  <= miss_cnt;
            state     <= S_IDLE;
          end else begin
            state <= S_HOLD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/tlbrep_checker.sv
// Port-level checks of the TLB replacement block, bound to its top level.
// Depends on tlb_lru_lfu_replacement_top_defines.svh and tlbrep_pkg.
`include "tlb_lru_lfu_replacement_top_defines.svh"

module tlbrep_port_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic                         rsp_hit,
  input logic [tlbrep_pkg::CNT_W-1:0] rsp_miss_total
);

  // A waiting result word keeps its miss total.
  `TLBREP_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_miss_total), "stalled")

  // After a page word is taken the block is busy with it.
  `TLBREP_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "page word taken while busy")

  // A miss counts until the total saturates, so a miss result never shows a zero total.
  `TLBREP_IMPLY(a_miss_counts, rsp_valid && !rsp_hit, rsp_miss_total != '0, "miss with zero total")

endmodule

bind tlb_lru_lfu_replacement_top tlbrep_port_checker u_tlbrep_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_hit        (rsp.hit),
  .rsp_miss_total (rsp.miss_total)
);
